FILE: hdl/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg: shared types for the sample standard deviation block
// Set summary passed from the accumulator front to the math back end.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned CntW = 11;
  localparam int unsigned SumW = 27;
  localparam int unsigned SqW  = 41;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatFew     = 2'd1;
  localparam logic [1:0] StatDropped = 2'd2;

  typedef struct packed {
    logic [CntW-1:0]        count;
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]         sum_sq;
    logic                   dropped;
  } set_sum_t;

endpackage

FILE: hdl/ssd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_front: sample accumulator
// Accumulates count, sum and sum of squares; emits a set summary on last.
// ----------------------------------------------------------------------------
module ssd_front #(
  parameter int unsigned MaxSamples = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [15:0]  sample_i,
  input  logic                last_i,
  output logic                sum_valid_o,
  input  logic                sum_ready_i,
  output ssd_pkg::set_sum_t   sum_o
);
  import ssd_pkg::*;

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]         sq_q, sq_d;
  logic                   drop_q, drop_d;
  logic                   ov_q, ov_d;
  set_sum_t               out_q, out_d;
  logic                   acc;
  logic                   room;
  logic [31:0]            sq;

  assign ready_o = !ov_q || sum_ready_i;
  assign acc     = valid_i && ready_o;
  assign room    = cnt_q < CntW'(MaxSamples);
  assign sq      = 32'(signed'(sample_i) * signed'(sample_i));

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    sq_d   = sq_q;
    drop_d = drop_q;
    ov_d   = ov_q && !sum_ready_i;
    out_d  = out_q;
    if (acc) begin
      if (room) begin
        cnt_d = cnt_q + 1'b1;
        sum_d = sum_q + SumW'(sample_i);
        sq_d  = sq_q + SqW'(sq);
      end else begin
        drop_d = 1'b1;
      end
      if (last_i) begin
        out_d = '{count: cnt_d, sum: sum_d, sum_sq: sq_d, dropped: drop_d};
        ov_d  = 1'b1;
        cnt_d = '0;
        sum_d = '0;
        sq_d  = '0;
        drop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      drop_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      sq_q   <= sq_d;
      drop_q <= drop_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sum_valid_o = ov_q;
  assign sum_o       = out_q;
endmodule

FILE: hdl/ssd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_fifo: two-entry set summary queue
// Decouples the accumulator from the divide and root sequencer.
// ----------------------------------------------------------------------------
module ssd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  ssd_pkg::set_sum_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output ssd_pkg::set_sum_t rd_data_o
);
  import ssd_pkg::*;

  set_sum_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

FILE: hdl/ssd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_back: variance and square root sequencer
// Computes N*sum_sq - sum^2, divides by N*(N-1) bit-serially, then takes the
// integer square root two bits per step, with an output register.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssd_pkg::set_sum_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       deviation_o,
  output logic [1:0]        status_o
);
  import ssd_pkg::*;

  localparam int unsigned NumW = 52;
  localparam int unsigned DenW = 20;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]      st_q, st_d;
  set_sum_t        in_q;
  logic [NumW-1:0] a_q, a_d;       // n*sum_sq, later numerator / quotient
  logic [NumW-1:0] b_q, b_d;       // sum^2
  logic [DenW-1:0] den_q, den_d;
  logic [NumW:0]   rem_q, rem_d;
  logic [5:0]      it_q, it_d;
  logic [NumW-1:0] v_q, v_d;
  logic [NumW-1:0] res_q, res_d;
  logic [NumW-1:0] bit_q, bit_d;
  logic [15:0]     dev_q, dev_d;
  logic [1:0]      stat_q, stat_d;
  logic [SumW-1:0] mag;
  logic [NumW:0]   rsh;

  assign mag = in_q.sum[SumW-1] ? SumW'(-in_q.sum) : SumW'(in_q.sum);
  assign in_ready_o  = st_q == StIdle;
  assign out_valid_o = st_q == StOut;
  assign deviation_o = dev_q;
  assign status_o    = stat_q;
  assign rsh = {rem_q[NumW-1:0], a_q[NumW-1]};

  always_comb begin
    st_d = st_q; a_d = a_q; b_d = b_q; den_d = den_q; rem_d = rem_q;
    it_d = it_q; v_d = v_q; res_d = res_q; bit_d = bit_q;
    dev_d = dev_q; stat_d = stat_q;
    case (st_q)
      StIdle: begin
        if (in_valid_i) st_d = StMul;
      end
      StMul: begin
        a_d   = NumW'(in_q.sum_sq) * NumW'(in_q.count);
        b_d   = NumW'(mag) * NumW'(mag);
        den_d = DenW'(in_q.count) * DenW'(in_q.count - 1'b1);
        rem_d = '0;
        it_d  = '0;
        if (in_q.count < CntW'(2)) begin
          dev_d = '0; stat_d = StatFew; st_d = StOut;
        end else begin
          stat_d = in_q.dropped ? StatDropped : StatOk;
          st_d = StDiv;
        end
      end
      StDiv: begin
        if (it_q == 6'd0 && b_q != '0) begin
          a_d = a_q - b_q;
          b_d = '0;
        end else begin
          if (rsh >= (NumW+1)'(den_q)) begin
            rem_d = rsh - (NumW+1)'(den_q);
            a_d   = {a_q[NumW-2:0], 1'b1};
          end else begin
            rem_d = rsh;
            a_d   = {a_q[NumW-2:0], 1'b0};
          end
          it_d = it_q + 1'b1;
          if (it_q == 6'(NumW-1)) begin
            st_d = StSqrt;
            it_d = '0;
          end
        end
      end
      StSqrt: begin
        if (it_q == 6'd0) begin
          v_d = a_q; res_d = '0;
          bit_d = NumW'(1) << (NumW-2);
          it_d = 6'd1;
        end else if (bit_q == '0) begin
          dev_d = (res_q > NumW'(16'hFFFF)) ? 16'hFFFF : res_q[15:0];
          st_d = StOut;
        end else begin
          if (v_q >= res_q + bit_q) begin
            v_d = v_q - (res_q + bit_q);
            res_d = (res_q >> 1) + bit_q;
          end else begin
            res_d = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      StOut: begin
        if (out_ready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else         st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    a_q <= a_d; b_q <= b_d; den_q <= den_d; rem_q <= rem_d; it_q <= it_d;
    v_q <= v_d; res_q <= res_d; bit_q <= bit_d; dev_q <= dev_d; stat_q <= stat_d;
  end
endmodule

FILE: hdl/sample_standard_deviation.sv
`timescale 1ns / 1ps
// Path: a closing sample's result passes the queue, products, 52-step restoring
//   divide and 26-step root; a set summing to zero skips the subtraction.
// Throughput: one sample per cycle while accumulating, unless a closed set waits
//   for a full queue; the back end takes a new set only once it is idle, so
//   short sets are paced by the back end.
// Reset: asynchronous active-low clears accumulators, queue and sequencer.
// ----------------------------------------------------------------------------
// sample_standard_deviation: streaming sample standard deviation
// Q8.8 samples in, floor sqrt of unbiased variance out, one result per set.
// ----------------------------------------------------------------------------
module sample_standard_deviation #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] deviation
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import ssd_pkg::*;

  // Front accumulates, queue holds closed sets, back does the math.
  logic     f_valid, f_ready, q_valid, q_ready;
  set_sum_t f_data, q_data;

  ssd_front #(.MaxSamples(MAX_SAMPLES)) u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .sample_i(s_axis_tdata), .last_i(s_axis_tlast),
    .sum_valid_o(f_valid), .sum_ready_i(f_ready), .sum_o(f_data)
  );

  ssd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_data)
  );

  ssd_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .deviation_o(m_axis_tdata), .status_o(m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // Status code 3 never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3) else $error("bad status");
  // A too-few-samples result carries zero deviation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == StatFew) |-> m_axis_tdata == 16'd0)
    else $error("nonzero deviation on short set");
  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
`endif
endmodule
